/* rtl/core/cms_pkg.sv */
// Shared constants, types and helper functions for the canonical minimizer
// signature core. No dependencies; every module of the core but cms_checker imports it.
package cms_pkg;

    localparam int MAX_SIG_LEN   = 11;
    localparam int MIN_SIG_LEN   = 4;
    localparam int LEN_W         = 4;
    localparam int WIN_W         = 2 * MAX_SIG_LEN;
    localparam int SIG_W         = WIN_W + 1;
    localparam int ADDR_W        = 3;

    localparam logic [LEN_W-1:0] SIG_LEN_RESET = 4'd9;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_SIG_LEN = 1'b0;

    // Disallowed-signature patterns.
    localparam logic [5:0] SFX_TTT     = 6'h3f;
    localparam logic [5:0] SFX_TGT     = 6'h3b;
    localparam logic [5:0] SFX_TG_MASK = 6'h3c;
    localparam logic [3:0] PAIR_MASK   = 4'hf;
    localparam logic [5:0] PFX_ACA     = 6'h04;

    typedef struct packed {
        logic [LEN_W-1:0] len;    // clamped signature length
        logic             clear;  // restart the current k-mer
    } cms_cfg_t;

    function automatic logic [LEN_W-1:0] cms_clamp_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] m;
        m = raw;
        if (m < LEN_W'(MIN_SIG_LEN)) m = LEN_W'(MIN_SIG_LEN);
        if (m > LEN_W'(MAX_SIG_LEN)) m = LEN_W'(MAX_SIG_LEN);
        return m;
    endfunction

    function automatic logic [SIG_W-1:0] cms_sentinel(input logic [LEN_W-1:0] len);
        return SIG_W'(1) << {len, 1'b0};
    endfunction

    function automatic logic [WIN_W-1:0] cms_win_mask(input logic [LEN_W-1:0] len);
        logic [SIG_W-1:0] s;
        s = cms_sentinel(len) - SIG_W'(1);
        return s[WIN_W-1:0];
    endfunction

endpackage

/* rtl/core/cms_apb_regs.sv */
// APB-style configuration register for the signature length.
// Depends on cms_pkg; drives the clamped length and a restart pulse.
module cms_apb_regs
    import cms_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cms_cfg_t          cfg
);

    logic [LEN_W-1:0] sig_len_reg;
    logic [LEN_W-1:0] sig_len_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SIG_LEN);

    always_comb begin
        sig_len_next = sig_len_reg;
        if (wr_en) begin
            sig_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_len_reg <= SIG_LEN_RESET;
        end else begin
            sig_len_reg <= sig_len_next;
        end
    end

    // The k-mer restarts in the same edge the new length lands. During the
    // write the tracker already sees the incoming length, so the restart
    // loads the sentinel of the new length.
    assign cfg.len   = cms_clamp_len(sig_len_next);
    assign cfg.clear = wr_en;

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1] == REG_SIG_LEN) begin
            prdata = {{(32-LEN_W){1'b0}}, sig_len_reg};
        end
    end

endmodule

/* rtl/core/cms_sig_check.sv */
// Allowed-signature test on one window code of the current length.
// Depends on cms_pkg; purely combinational.
module cms_sig_check
    import cms_pkg::*;
(
    input  logic [WIN_W-1:0] code,
    input  logic [LEN_W-1:0] len,
    output logic             ok
);

    logic       pair_hit;
    logic [5:0] pfx;
    logic [LEN_W-1:0] pfx_pos;

    // Every base pair below the three leading bases is checked at once.
    always_comb begin
        pair_hit = 1'b0;
        for (int j = 0; j <= MAX_SIG_LEN - 4; j++) begin
            if ((LEN_W'(j + 3) < len) && ((code[2*j +: 4] & PAIR_MASK) == 4'h0)) begin
                pair_hit = 1'b1;
            end
        end
    end

    assign pfx_pos = len - LEN_W'(3);
    assign pfx     = 6'(code >> {pfx_pos, 1'b0});

    always_comb begin
        ok = 1'b1;
        if (code[5:0] == SFX_TTT || code[5:0] == SFX_TGT
            || (code[5:0] & SFX_TG_MASK) == SFX_TG_MASK) begin
            ok = 1'b0;
        end
        if (pair_hit) begin
            ok = 1'b0;
        end
        if (pfx == 6'h00 || pfx == PFX_ACA || pfx[3:0] == 4'h0) begin
            ok = 1'b0;
        end
    end

endmodule

/* rtl/core/cms_track.sv */
// Window state and running minimum for the k-mer in progress.
// Depends on cms_pkg and cms_sig_check; updates once per processed base.
module cms_track
    import cms_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cms_cfg_t         cfg,
    input  logic             step,
    input  logic [1:0]       base,
    input  logic             last,
    output logic [SIG_W-1:0] res_code,
    output logic             res_none
);

    logic [WIN_W-1:0] fwd_reg, fwd_next;
    logic [WIN_W-1:0] rev_reg, rev_next;
    logic [SIG_W-1:0] best_reg, best_next;
    logic [LEN_W-1:0] fill_reg, fill_next;

    logic [WIN_W-1:0] mask;
    logic [WIN_W-1:0] fwd_win, rev_win;
    logic [LEN_W-1:0] fill_inc;
    logic [LEN_W-1:0] top_pos;
    logic             full, fwd_ok, rev_ok;
    logic [SIG_W-1:0] best_a, best_b;
    logic [SIG_W-1:0] sent;

    assign mask    = cms_win_mask(cfg.len);
    assign sent    = cms_sentinel(cfg.len);
    assign top_pos = cfg.len - LEN_W'(1);

    // The reverse strand takes the complement of each base at the top end.
    assign fwd_win = {fwd_reg[WIN_W-3:0], base} & mask;
    assign rev_win = ({2'b00, rev_reg[WIN_W-1:2]}
                     | (WIN_W'(~base) << {top_pos, 1'b0})) & mask;

    assign fill_inc = (fill_reg < cfg.len) ? fill_reg + LEN_W'(1) : fill_reg;
    assign full     = (fill_inc >= cfg.len);

    cms_sig_check u_fwd_chk (.code(fwd_win), .len(cfg.len), .ok(fwd_ok));
    cms_sig_check u_rev_chk (.code(rev_win), .len(cfg.len), .ok(rev_ok));

    always_comb begin
        best_a = best_reg;
        if (full && fwd_ok && ({1'b0, fwd_win} < best_reg)) begin
            best_a = {1'b0, fwd_win};
        end
        best_b = best_a;
        if (full && rev_ok && ({1'b0, rev_win} < best_a)) begin
            best_b = {1'b0, rev_win};
        end
    end

    assign res_code = best_b;
    assign res_none = (best_b == sent);

    always_comb begin
        fwd_next  = fwd_reg;
        rev_next  = rev_reg;
        best_next = best_reg;
        fill_next = fill_reg;
        if (cfg.clear || (step && last)) begin
            fwd_next  = '0;
            rev_next  = '0;
            best_next = sent;
            fill_next = '0;
        end else if (step) begin
            fwd_next  = fwd_win;
            rev_next  = rev_win;
            best_next = best_b;
            fill_next = fill_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg  <= '0;
            rev_reg  <= '0;
            best_reg <= cms_sentinel(cms_clamp_len(SIG_LEN_RESET));
            fill_reg <= '0;
        end else begin
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            best_reg <= best_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* rtl/core/canonical_minimizer_signature_core.sv */
// Top level of the canonical minimizer signature core: input register,
// window tracker, result register and configuration port (cms_pkg, cms_*).
//
//  Channel   Ports                     Payload
//  --------  ------------------------  ---------------------------------------
//  input     s_tvalid/s_tready         s_tdata[1:0] base, s_tlast last base
//  result    m_tvalid/m_tready         m_tdata[22:0] signature, m_tuser none
//  config    psel/penable/pwrite/...   signature_len at byte address 0
//
// One base is taken per cycle while s_tready is high; the window update, both strand tests and the
// minimum compare close through the tracker state registers.
// The result register loads when the last base of a k-mer steps out of the input
// register into the tracker, and m_tvalid rises together with it.
// Reset is synchronous and clears the channel valids and the k-mer state.
// s_tready drops only while a last base waits for a full result register.
module canonical_minimizer_signature_core
    import cms_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [1:0] base
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [22:0] signature
    output logic              m_tuser,   // [0] none_allowed
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cms_cfg_t         cfg;
    logic             in_valid_reg, in_valid_next;
    logic [1:0]       in_base_reg;
    logic             in_last_reg;
    logic             out_valid_reg, out_valid_next;
    logic [SIG_W-1:0] out_sig_reg;
    logic             out_none_reg;
    logic             step;
    logic             s_xfer;
    logic [SIG_W-1:0] res_code;
    logic             res_none;

    cms_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A base moves on unless it ends a k-mer and the result slot is still full.
    assign step     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    cms_track u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (step),
        .base     (in_base_reg),
        .last     (in_last_reg),
        .res_code (res_code),
        .res_none (res_none)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_base_reg <= s_tdata[1:0];
            in_last_reg <= s_tlast;
        end
        if (step && in_last_reg) begin
            out_sig_reg  <= res_code;
            out_none_reg <= res_none;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-SIG_W){1'b0}}, out_sig_reg};
    assign m_tuser  = out_none_reg;

endmodule

/* rtl/core/cms_checker.sv */
// Port-level checks on the result channel of the canonical minimizer
// signature core, attached by the bind below. No package dependency.
module cms_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [23:0]       m_tdata,
    input logic              m_tuser
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // With no allowed window the signature is the power-of-four sentinel.
    a_none_sentinel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> $onehot(m_tdata) && (m_tdata[7:0] == 8'h00))
        else $error("none_allowed without a sentinel signature");

    // An allowed signature always fits in the window width.
    a_allowed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[23:22] == 2'b00))
        else $error("allowed signature out of range");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind canonical_minimizer_signature_core cms_checker u_cms_checker (.*);
